FILE: hw/rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and status codes for the JSON string
// unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// parser mode
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_STR  = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} mode_t;

	// result status codes
	localparam logic [2:0] ST_DATA     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_BADSTART = 3'd2;
	localparam logic [2:0] ST_BADHEX   = 3'd3;
	localparam logic [2:0] ST_UNTERM   = 3'd4;

	// characters of interest
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// all results caused by one input byte
	typedef struct packed {
		logic [2:0][7:0] data;       // decoded bytes, data[0] first
		logic [1:0]      nbytes;     // number of valid bytes, 0 to 3
		logic            has_status; // one status result after the bytes
		logic [2:0]      status;
	} bundle_t;

	// hex digit decode: {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw bytes, tracks the string parser state and turns each byte into
// a bundle of up to three decoded bytes and one status.
// ----------------------------------------------------------------------------
module jsu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            start_flag,
	input  logic            final_flag,
	input  logic            q_full,
	output logic            push,
	output jsu_pkg::bundle_t bundle
);
	import jsu_pkg::*;

	mode_t       mode_q, mode_mid, mode_d;
	logic [1:0]  hex_q, hex_mid, hex_d;
	logic [15:0] acc_q, acc_mid, acc_d, acc_new;
	logic [4:0]  dig;
	logic        accept;

	assign in_ready = ~q_full;
	assign accept   = in_valid & in_ready;
	assign dig      = hex_digit(in_byte);
	assign acc_new  = {acc_q[11:0], dig[3:0]};

	// next state: byte step, then end-of-input check
	always_comb begin
		mode_mid = mode_q;
		hex_mid  = hex_q;
		acc_mid  = acc_q;
		if (start_flag) begin
			hex_mid  = 2'd0;
			acc_mid  = 16'd0;
			mode_mid = (in_byte == CH_QUOTE) ? MODE_STR : MODE_IDLE;
		end else begin
			unique case (mode_q)
				MODE_STR: begin
					if (in_byte == CH_QUOTE) begin
						mode_mid = MODE_IDLE;
					end else if (in_byte == CH_BSLASH) begin
						mode_mid = MODE_ESC;
					end
				end
				MODE_ESC: begin
					mode_mid = MODE_STR;
					if (in_byte == CH_U) begin
						mode_mid = MODE_HEX;
						hex_mid  = 2'd0;
						acc_mid  = 16'd0;
					end
				end
				MODE_HEX: begin
					if (!dig[4]) begin
						mode_mid = MODE_IDLE;
						hex_mid  = 2'd0;
					end else begin
						acc_mid = acc_new;
						hex_mid = hex_q + 2'd1;
						if (hex_q == 2'd3) begin
							mode_mid = MODE_STR;
						end
					end
				end
				default: begin
				end
			endcase
		end
		mode_d = mode_mid;
		hex_d  = hex_mid;
		acc_d  = acc_mid;
		if (final_flag && mode_mid != MODE_IDLE) begin
			mode_d = MODE_IDLE;
			hex_d  = 2'd0;
		end
	end

	// outputs: results caused by this byte
	always_comb begin
		bundle = '0;
		if (start_flag) begin
			if (in_byte != CH_QUOTE) begin
				bundle.has_status = 1'b1;
				bundle.status     = ST_BADSTART;
			end
		end else begin
			unique case (mode_q)
				MODE_STR: begin
					if (in_byte == CH_QUOTE) begin
						bundle.has_status = 1'b1;
						bundle.status     = ST_DONE;
					end else if (in_byte != CH_BSLASH) begin
						bundle.nbytes  = 2'd1;
						bundle.data[0] = in_byte;
					end
				end
				MODE_ESC: begin
					bundle.nbytes = 2'd1;
					unique case (in_byte)
						CH_B:    bundle.data[0] = 8'h08;
						CH_F:    bundle.data[0] = 8'h0c;
						CH_N:    bundle.data[0] = 8'h0a;
						CH_R:    bundle.data[0] = 8'h0d;
						CH_T:    bundle.data[0] = 8'h09;
						CH_U:    bundle.nbytes  = 2'd0;
						default: bundle.data[0] = in_byte;
					endcase
				end
				MODE_HEX: begin
					if (!dig[4]) begin
						bundle.has_status = 1'b1;
						bundle.status     = ST_BADHEX;
					end else if (hex_q == 2'd3) begin
						// utf-8 encode of the completed code unit
						if (acc_new <= 16'h007f) begin
							bundle.nbytes  = 2'd1;
							bundle.data[0] = acc_new[7:0];
						end else if (acc_new <= 16'h07ff) begin
							bundle.nbytes  = 2'd2;
							bundle.data[0] = {3'b110, acc_new[10:6]};
							bundle.data[1] = {2'b10, acc_new[5:0]};
						end else begin
							bundle.nbytes  = 2'd3;
							bundle.data[0] = {4'b1110, acc_new[15:12]};
							bundle.data[1] = {2'b10, acc_new[11:6]};
							bundle.data[2] = {2'b10, acc_new[5:0]};
						end
					end
				end
				default: begin
				end
			endcase
		end
		// input ended inside the string
		if (final_flag && mode_mid != MODE_IDLE) begin
			bundle.has_status = 1'b1;
			bundle.status     = (mode_mid == MODE_HEX) ? ST_BADHEX : ST_UNTERM;
		end
	end

	assign push = accept & ((bundle.nbytes != 2'd0) | bundle.has_status);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			hex_q  <= 2'd0;
			acc_q  <= 16'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			hex_q  <= hex_d;
			acc_q  <= acc_d;
		end
	end

endmodule

FILE: hw/rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short bundle queue that decouples the parser front from the result back.
// ----------------------------------------------------------------------------
module jsu_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsu_pkg::bundle_t wr_data,
	input  logic             pop,
	output jsu_pkg::bundle_t rd_data,
	output logic             full,
	output logic             empty
);
	import jsu_pkg::*;

	bundle_t        mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full    = (count_q == (QAW+1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");

endmodule

FILE: hw/rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Walks the head bundle one result per cycle into the output register while out_ready does not stall it.
// ----------------------------------------------------------------------------
module jsu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  jsu_pkg::bundle_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic [2:0]       status,
	output logic             last
);
	import jsu_pkg::*;

	logic [1:0] idx_q;
	logic [2:0] total;
	logic       load, is_last, is_byte;
	logic [7:0] sel_byte;
	logic       out_valid_q, byte_valid_q, last_q;
	logic [7:0] out_byte_q;
	logic [2:0] status_q;

	// pick the current result of the head bundle
	assign total   = {1'b0, head.nbytes} + {2'b00, head.has_status};
	assign is_last = (({1'b0, idx_q} + 3'd1) == total);
	assign is_byte = (idx_q < head.nbytes);
	assign load    = ~empty & (~out_valid_q | out_ready);
	assign pop     = load & is_last;

	always_comb begin
		unique case (idx_q)
			2'd0:    sel_byte = head.data[0];
			2'd1:    sel_byte = head.data[1];
			default: sel_byte = head.data[2];
		endcase
	end

	// result index within the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (load) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= is_byte ? sel_byte : 8'd0;
			byte_valid_q <= is_byte;
			status_q     <= is_byte ? ST_DATA : head.status;
			last_q       <= is_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign status     = status_q;
	assign last       = last_q;

	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ({1'b0, idx_q} < total)) else $error("result index past bundle");
	a_byte_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && byte_valid_q) |-> (status_q == ST_DATA))
		else $error("byte result with non-data status");

endmodule

FILE: hw/rtl/json_string_unescaper_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_utf8
// Decodes one JSON string literal from a byte stream into UTF-8 bytes and
// status results.
// ----------------------------------------------------------------------------
// Takes one input byte per cycle while the bundle queue has room. Each byte
// yields zero to four results (decoded bytes, then at most one status);
// results leave one per cycle through a registered output while out_ready
// does not stall it. A four-entry bundle queue between the parser and the
// output walker absorbs bursts: input stalls only when that queue is full.
// Bytes that give no result (idle bytes, a backslash, hex digits before the
// fourth) never enter the queue. No clearing pass after reset.
module json_string_unescaper_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       start_flag,
	input  logic       final_flag,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic [2:0] status,
	output logic       last
);
	import jsu_pkg::*;

	bundle_t wr_bundle, head;
	logic    push, pop, q_full, q_empty;

	// parser front
	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.start_flag (start_flag),
		.final_flag (final_flag),
		.q_full     (q_full),
		.push       (push),
		.bundle     (wr_bundle)
	);

	// bundle queue
	jsu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_bundle),
		.pop     (pop),
		.rd_data (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	// result back end
	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.status     (status),
		.last       (last)
	);

endmodule
